@@ hw/rtl/csfd_pkg.sv @@
// Package for the sensor frame decoder: state and item types, constants and
// the CRC-8 (poly 0x07) helper functions. No dependencies.
package csfd_pkg;

  localparam int unsigned MsgBits = 56;   // bytes 0..6 covered by the CRC

  localparam logic [7:0]  CrcPoly       = 8'h07;
  localparam logic [31:0] ZeroOffset    = 32'h8000_0000;
  localparam logic [7:0]  TimeoutReset  = 8'd10;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic [MsgBits-1:0][7:0] crc_col_t;

  // Decoder state kept between items
  typedef struct packed {
    logic [31:0] raw_value;
    logic        error_bit;
    logic [6:0]  error_info;
    logic [15:0] aux_data;
    logic [7:0]  timeout_left;
  } csfd_state_t;

  // One input item
  typedef struct packed {
    logic        mode;
    logic [63:0] frame_data;
  } csfd_item_t;

  // Column j holds x^(j+8) mod P: the CRC contribution of message bit j.
  // Only evaluated at elaboration.
  function automatic crc_col_t crc_columns();
    crc_col_t   cols;
    logic [7:0] r;
    r = 8'h01;
    cols = '0;
    for (int j = 0; j < MsgBits + 8; j++) begin
      if (j >= 8) begin
        cols[j-8] = r;
      end
      r = r[7] ? ({r[6:0], 1'b0} ^ CrcPoly) : {r[6:0], 1'b0};
    end
    return cols;
  endfunction

  localparam crc_col_t CrcCols = crc_columns();

  // CRC-8 over 56 message bits as an XOR of independent columns
  function automatic logic [7:0] crc8_msg(input logic [MsgBits-1:0] msg);
    logic [7:0] acc;
    acc = '0;
    for (int j = 0; j < MsgBits; j++) begin
      acc = acc ^ (msg[j] ? CrcCols[j] : 8'h00);
    end
    return acc;
  endfunction

endpackage

@@ hw/rtl/current_sensor_frame_decoder.sv @@
// Current sensor frame decoder, top level: input register, state update and
// result register. Depends on csfd_pkg and csfd_step.
//
// Usage:
//   in_*  : one item per handshake; in_mode 0 carries an 8-byte frame in
//           in_frame_data (byte 0 in bits 63:56, CRC in bits 7:0), in_mode 1
//           is a timeout tick and the frame bits are ignored.
//   out_* : one result item per input item, in order: current in mA (raw
//           value minus the zero offset), stored status fields, crc_match for
//           this item and stale when the timeout counter sits at zero.
//   cfg_* : writes the timeout reload value; cfg_ready is always high.
// An accepted item moves from the input register to the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the combinational CRC and state update between the input and result registers.
// Reset (synchronous, rst_n low) empties both registers, sets the raw value
// to the zero offset, clears the status and timeout counter and loads the
// timeout reload value with 10.
// When the receiver stalls the result is held; one more item is taken into
// the input register, after which in_ready drops until the result is taken.
module current_sensor_frame_decoder import csfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [63:0]        in_frame_data,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_current_ma,
  output logic               out_error_flag,
  output logic [6:0]         out_error_code,
  output logic [15:0]        out_aux_word,
  output logic               out_crc_match,
  output logic               out_stale,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_timeout_ticks
);

  logic [7:0]  tmo_ticks_r;
  csfd_item_t  item_r;
  logic        item_valid_r;
  csfd_state_t state_r;
  csfd_state_t state_nxt;
  logic        match_nxt;
  logic        out_free;
  logic        advance;

  logic signed [31:0] current_r;
  logic               error_flag_r;
  logic [6:0]         error_code_r;
  logic [15:0]        aux_word_r;
  logic               crc_match_r;
  logic               stale_r;
  logic               out_valid_r;

  // Handshake control
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = item_valid_r && out_free;
  assign in_ready  = !item_valid_r || out_free;
  assign cfg_ready = 1'b1;

  // Timeout reload register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_ticks_r <= TimeoutReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tmo_ticks_r <= cfg_timeout_ticks;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode       <= in_mode;
      item_r.frame_data <= in_frame_data;
    end
  end

  csfd_step u_step (
    .item          (item_r),
    .state_cur     (state_r),
    .timeout_ticks (tmo_ticks_r),
    .state_nxt     (state_nxt),
    .crc_match     (match_nxt)
  );

  // Decoder state, updated as each item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.raw_value    <= ZeroOffset;
      state_r.error_bit    <= 1'b0;
      state_r.error_info   <= '0;
      state_r.aux_data     <= '0;
      state_r.timeout_left <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current_r    <= $signed(state_nxt.raw_value ^ ZeroOffset);
      error_flag_r <= state_nxt.error_bit;
      error_code_r <= state_nxt.error_info;
      aux_word_r   <= state_nxt.aux_data;
      crc_match_r  <= match_nxt;
      stale_r      <= (state_nxt.timeout_left == 8'd0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_current_ma = current_r;
  assign out_error_flag = error_flag_r;
  assign out_error_code = error_code_r;
  assign out_aux_word   = aux_word_r;
  assign out_crc_match  = crc_match_r;
  assign out_stale      = stale_r;

endmodule

@@ hw/rtl/csfd_step.sv @@
// Next-state logic of the sensor frame decoder for one item: CRC check,
// field capture and tick timeout. Depends on csfd_pkg.
module csfd_step import csfd_pkg::*; (
  input  csfd_item_t  item,
  input  csfd_state_t state_cur,
  input  logic [7:0]  timeout_ticks,
  output csfd_state_t state_nxt,
  output logic        crc_match
);

  logic [7:0] crc_calc;
  logic [7:0] byte4;

  assign crc_calc = crc8_msg(item.frame_data[63:8]);
  assign byte4    = item.frame_data[31:24];

  // Frame: reload timeout, capture on CRC match. Tick: count down or force offset.
  always_comb begin
    state_nxt = state_cur;
    crc_match = 1'b0;
    if (item.mode == MODE_FRAME) begin
      state_nxt.timeout_left = timeout_ticks;
      if (crc_calc == item.frame_data[7:0]) begin
        crc_match            = 1'b1;
        state_nxt.aux_data   = item.frame_data[23:8];
        state_nxt.error_info = byte4[7:1];
        state_nxt.error_bit  = byte4[0];
        state_nxt.raw_value  = byte4[0] ? ZeroOffset : item.frame_data[63:32];
      end
    end else begin
      if (state_cur.timeout_left != 8'd0) begin
        state_nxt.timeout_left = state_cur.timeout_left - 8'd1;
      end else begin
        state_nxt.raw_value = ZeroOffset;
      end
    end
  end

endmodule
